// ===== rtl/ncl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ncl_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [7:0] ADV_TYPE = 8'd136;
  localparam logic [15:0] MIN_LEN = 16'd2;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_MESSAGE = 1'b1;

  localparam int IN_DATA_W = 200;
  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic [15:0] message_length;
    logic [7:0] message_type;
    logic [47:0] source_tail;
    logic [63:0] target_low;
    logic [63:0] target_high;
  } item_t;

  typedef struct packed {
    logic table_full;
    logic written;
    logic [3:0] entry_index;
    logic [47:0] mac;
    logic hit;
  } result_t;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [47:0] mac;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last_issued;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/ncl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ncl_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ncl_pkg::status_t status,
  output ncl_pkg::cmd_t        cmd
);
  import ncl_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.last_issued) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ncl_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ncl_dpath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ncl_pkg::cmd_t    cmd,
  output ncl_pkg::status_t      status,
  input  wire logic             in_func,
  input  wire ncl_pkg::item_t   in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ncl_pkg::result_t      out_result
);
  import ncl_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rd_q;
  logic [ENTRIES-1:0] entry_valid;

  logic func_q;
  item_t item_q;

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] rd_idx;
  logic rd_pend;

  logic match_found;
  logic [IDX_W-1:0] match_idx;
  logic [47:0] match_mac;
  logic free_found;
  logic [IDX_W-1:0] free_idx;

  logic rd_match;
  logic adv;
  logic slot_ok;
  logic [IDX_W-1:0] slot;
  logic wr_en;
  logic [IDX_W+3:0] slot_ext;
  logic [IDX_W+3:0] match_ext;
  result_t result_next;

  assign status.last_issued = (idx == IDX_W'(ENTRIES - 1));
  assign status.out_busy = out_valid && !out_ready;

  assign rd_match = rd_pend && entry_valid[rd_idx]
                    && (rd_q.addr_high == item_q.target_high)
                    && (rd_q.addr_low == item_q.target_low);

  assign adv = (func_q == FUNC_MESSAGE) && (item_q.message_type == ADV_TYPE)
               && (item_q.message_length >= MIN_LEN);
  assign slot_ok = match_found || free_found;
  assign slot = match_found ? match_idx : free_idx;
  assign wr_en = cmd.finish && adv && slot_ok;
  assign slot_ext = {4'b0, slot};
  assign match_ext = {4'b0, match_idx};

  always_comb begin
    result_next = '0;
    if (func_q == FUNC_LOOKUP) begin
      if (match_found) begin
        result_next.hit = 1'b1;
        result_next.mac = match_mac;
        result_next.entry_index = match_ext[3:0];
      end
    end else if (adv) begin
      if (slot_ok) begin
        result_next.written = 1'b1;
        result_next.entry_index = slot_ext[3:0];
      end else begin
        result_next.table_full = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_q <= mem[idx];
    end
    if (wr_en) begin
      mem[slot] <= '{addr_high: item_q.target_high, addr_low: item_q.target_low,
                     mac: item_q.source_tail};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= in_func;
      item_q <= in_item;
    end
    if (cmd.load) begin
      idx <= '0;
    end else if (cmd.scan) begin
      idx <= idx + 1'b1;
    end
    rd_idx <= idx;
    if (cmd.load) begin
      match_found <= 1'b0;
      free_found <= 1'b0;
    end else if (rd_pend) begin
      if (rd_match && !match_found) begin
        match_found <= 1'b1;
        match_idx <= rd_idx;
        match_mac <= rd_q.mac;
      end
      if (!entry_valid[rd_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx <= rd_idx;
      end
    end
    if (cmd.finish) begin
      out_result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      entry_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= cmd.scan;
      if (wr_en) begin
        entry_valid[slot] <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/neighbor_cache_lookup_learn_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Neighbor cache of ENTRIES fully associative entries, each mapping a 128-bit
// IPv6 address to a 48-bit MAC. A lookup (tuser 0) returns hit, MAC and entry
// index; a neighbor message (tuser 1) that is an advertisement of at least two
// bytes refreshes the matching entry or fills the lowest free one, and is
// dropped with table_full set when no entry matches and none is free. Each
// item passes through the accept step, a scan of every entry in turn through
// the single read port of the entry memory, a drain step for the last compare
// and a finish step that writes back and loads the result. The result
// register lets a new item in while the previous result waits; a result not
// yet taken holds the block in its finish state. Valid marks clear at reset,
// so no clearing pass is needed.
module neighbor_cache_lookup_learn_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // target_high, target_low, source_tail, message_type, message_length
  input  wire logic [ncl_pkg::IN_DATA_W-1:0]  s_tdata,
  // func
  input  wire logic                           s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // hit, mac, entry_index, written, table_full, zero pad
  output logic [ncl_pkg::OUT_DATA_W-1:0]      m_tdata
);
  import ncl_pkg::*;

  cmd_t cmd;
  status_t status;
  item_t in_item;
  result_t out_result;

  assign in_item = item_t'(s_tdata);
  assign m_tdata = {1'b0, out_result};

  ncl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ncl_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_func    (s_tuser),
    .in_item    (in_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result)
  );

endmodule

`default_nettype wire

// ===== rtl/ncl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ncl_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [ncl_pkg::OUT_DATA_W-1:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after accept");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0({m_tdata[54], m_tdata[53], m_tdata[0]}))
    else $error("hit, written and table_full overlap");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[48:1] == 48'd0)
    else $error("mac nonzero without hit");

endmodule

bind neighbor_cache_lookup_learn_unit ncl_checker u_ncl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
